// File: design/tgfp_pkg.sv
// Shared types, constants and lookup tables for the tripod gait foot position block.
`timescale 1ns / 1ps
`default_nettype none

package tgfp_pkg;

	// Gait cycle and rotator geometry
	localparam int unsigned STEPS_PER_CYCLE = 22;
	localparam int unsigned HALF_STEPS      = STEPS_PER_CYCLE / 2;
	localparam int unsigned CORDIC_ITERS    = 14;
	localparam int unsigned ROT_PER_STAGE   = 2;
	localparam int unsigned ROT_STAGES      = CORDIC_ITERS / ROT_PER_STAGE;

	// CORDIC gain 0.607253 in Q15
	localparam logic [14:0] CORDIC_GAIN = 15'd19898;

	// Datapath widths and scaling
	localparam int unsigned ACC_W      = 32;
	localparam int unsigned SUM_W      = 34;
	localparam int unsigned ANG_W      = 16;
	localparam int unsigned TURN_W     = 18;
	localparam int unsigned ZSUM_W     = 6;
	localparam int unsigned FRAC_SHIFT = 19;
	localparam int unsigned TURN_SHIFT = 15;
	localparam int unsigned ROUND_BIT  = 18;

	// Output limits in sixteenths
	localparam int XY_LIMIT = 480;
	localparam int Z_LIMIT  = 320;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_SHIFT_MASK   = 2'd0,
		REG_SPEED_THRESH = 2'd1
	} cfg_reg_t;

	// One foot offset point of a step table
	typedef struct packed {
		logic signed [7:0] x;
		logic signed [7:0] y;
		logic signed [7:0] z;
	} foot_pt_t;

	// Rotator state between stages
	typedef struct packed {
		logic signed [ACC_W-1:0] x;
		logic signed [ACC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
	} cord_t;

	// Terms that ride alongside the rotator
	typedef struct packed {
		logic signed [TURN_W-1:0] tx;
		logic signed [TURN_W-1:0] ty;
		logic [ZSUM_W-1:0]        zsum;
		logic                     len;
		logic                     ten;
	} side_t;

	// Linear step table
	function automatic foot_pt_t line_pt(input logic [4:0] i);
		case (i)
			5'd0:    line_pt = '{8'sd0, 8'sd0, 8'sd0};
			5'd1:    line_pt = '{-8'sd5, 8'sd0, 8'sd0};
			5'd2:    line_pt = '{-8'sd10, 8'sd0, 8'sd0};
			5'd3:    line_pt = '{-8'sd15, 8'sd0, 8'sd0};
			5'd4:    line_pt = '{-8'sd20, 8'sd0, 8'sd0};
			5'd5:    line_pt = '{-8'sd25, 8'sd0, 8'sd0};
			5'd6:    line_pt = '{-8'sd25, 8'sd0, 8'sd5};
			5'd7:    line_pt = '{-8'sd18, 8'sd0, 8'sd10};
			5'd8:    line_pt = '{-8'sd10, 8'sd0, 8'sd15};
			5'd9:    line_pt = '{-8'sd2, 8'sd0, 8'sd20};
			5'd10:   line_pt = '{8'sd6, 8'sd0, 8'sd20};
			5'd11:   line_pt = '{8'sd0, 8'sd0, 8'sd20};
			5'd12:   line_pt = '{8'sd8, 8'sd0, 8'sd20};
			5'd13:   line_pt = '{8'sd15, 8'sd0, 8'sd20};
			5'd14:   line_pt = '{8'sd20, 8'sd0, 8'sd15};
			5'd15:   line_pt = '{8'sd24, 8'sd0, 8'sd10};
			5'd16:   line_pt = '{8'sd25, 8'sd0, 8'sd5};
			5'd17:   line_pt = '{8'sd25, 8'sd0, 8'sd0};
			5'd18:   line_pt = '{8'sd20, 8'sd0, 8'sd0};
			5'd19:   line_pt = '{8'sd15, 8'sd0, 8'sd0};
			5'd20:   line_pt = '{8'sd10, 8'sd0, 8'sd0};
			5'd21:   line_pt = '{8'sd5, 8'sd0, 8'sd0};
			default: line_pt = '{8'sd0, 8'sd0, 8'sd0};
		endcase
	endfunction

	// Turning step table
	function automatic foot_pt_t turn_pt(input logic [4:0] i);
		case (i)
			5'd0:    turn_pt = '{8'sd0, 8'sd0, 8'sd0};
			5'd1:    turn_pt = '{8'sd0, 8'sd8, 8'sd0};
			5'd2:    turn_pt = '{-8'sd1, 8'sd13, 8'sd0};
			5'd3:    turn_pt = '{-8'sd1, 8'sd18, 8'sd0};
			5'd4:    turn_pt = '{-8'sd2, 8'sd22, 8'sd0};
			5'd5:    turn_pt = '{-8'sd3, 8'sd27, 8'sd0};
			5'd6:    turn_pt = '{-8'sd3, 8'sd27, 8'sd5};
			5'd7:    turn_pt = '{-8'sd2, 8'sd22, 8'sd10};
			5'd8:    turn_pt = '{-8'sd1, 8'sd18, 8'sd15};
			5'd9:    turn_pt = '{-8'sd1, 8'sd13, 8'sd20};
			5'd10:   turn_pt = '{8'sd0, 8'sd8, 8'sd20};
			5'd11:   turn_pt = '{8'sd0, 8'sd0, 8'sd20};
			5'd12:   turn_pt = '{8'sd0, -8'sd8, 8'sd20};
			5'd13:   turn_pt = '{-8'sd1, -8'sd13, 8'sd20};
			5'd14:   turn_pt = '{-8'sd1, -8'sd18, 8'sd15};
			5'd15:   turn_pt = '{-8'sd2, -8'sd22, 8'sd10};
			5'd16:   turn_pt = '{-8'sd3, -8'sd27, 8'sd5};
			5'd17:   turn_pt = '{-8'sd3, -8'sd27, 8'sd0};
			5'd18:   turn_pt = '{-8'sd2, -8'sd22, 8'sd0};
			5'd19:   turn_pt = '{-8'sd1, -8'sd18, 8'sd0};
			5'd20:   turn_pt = '{-8'sd1, -8'sd13, 8'sd0};
			5'd21:   turn_pt = '{8'sd0, -8'sd8, 8'sd0};
			default: turn_pt = '{8'sd0, 8'sd0, 8'sd0};
		endcase
	endfunction

	// Arctangent of 2^-i in 1/65536 turn
	function automatic logic signed [ANG_W-1:0] atan_step(input int unsigned i);
		case (i)
			0:       atan_step = 16'sd8192;
			1:       atan_step = 16'sd4836;
			2:       atan_step = 16'sd2555;
			3:       atan_step = 16'sd1297;
			4:       atan_step = 16'sd651;
			5:       atan_step = 16'sd326;
			6:       atan_step = 16'sd163;
			7:       atan_step = 16'sd81;
			8:       atan_step = 16'sd41;
			9:       atan_step = 16'sd20;
			10:      atan_step = 16'sd10;
			11:      atan_step = 16'sd5;
			12:      atan_step = 16'sd3;
			13:      atan_step = 16'sd1;
			default: atan_step = 16'sd0;
		endcase
	endfunction

endpackage

`default_nettype wire

// File: design/tgfp_cordic_pair.sv
// One pipeline stage of the rotator: two CORDIC micro-rotations, registered.
`timescale 1ns / 1ps
`default_nettype none

module tgfp_cordic_pair #(
	parameter int unsigned FIRST = 0
) (
	input  wire               clk,
	input  wire               en,
	input  wire tgfp_pkg::cord_t d,
	output tgfp_pkg::cord_t   q
);
	import tgfp_pkg::*;

	cord_t mid;
	cord_t nxt;
	cord_t rot_q;

	// Rotate toward zero residual angle, first micro-rotation
	always_comb begin
		if (d.z >= 0) begin
			mid.x = d.x - (d.y >>> FIRST);
			mid.y = d.y + (d.x >>> FIRST);
			mid.z = d.z - atan_step(FIRST);
		end else begin
			mid.x = d.x + (d.y >>> FIRST);
			mid.y = d.y - (d.x >>> FIRST);
			mid.z = d.z + atan_step(FIRST);
		end
	end

	// Second micro-rotation
	always_comb begin
		if (mid.z >= 0) begin
			nxt.x = mid.x - (mid.y >>> (FIRST + 1));
			nxt.y = mid.y + (mid.x >>> (FIRST + 1));
			nxt.z = mid.z - atan_step(FIRST + 1);
		end else begin
			nxt.x = mid.x + (mid.y >>> (FIRST + 1));
			nxt.y = mid.y - (mid.x >>> (FIRST + 1));
			nxt.z = mid.z + atan_step(FIRST + 1);
		end
	end

	// Hold while the stage is stalled
	always_ff @(posedge clk) begin
		if (en) begin
			rot_q <= nxt;
		end
	end

	assign q = rot_q;

endmodule

`default_nettype wire

// File: design/tripod_gait_foot_position_top.sv
// Top level of the tripod gait foot position pipeline.
//
// Usage: present one query word on the input channel (leg_number, phase,
// linear_speed, heading, turn_speed) with in_valid; it is taken when in_ready
// is high. The block returns one result word (foot_x, foot_y, foot_z, signed
// sixteenths) on the output channel per query, in query order.
// Throughput: one word per cycle while out_ready is high. The depth is set by the seven rotator stages
// (two CORDIC micro-rotations each) plus table, multiply, quadrant, sum and
// round/clamp stages.
// Stall: each stage advances when it is empty or the stage after it advances,
// so bubbles close up and new words are taken while a result waits; with all
// twelve stages full, in_ready drops until out_ready returns.
// Configuration: cfg_index 0 writes shifted_leg_mask, 1 writes speed_threshold;
// other indexes are ignored. cfg_ready is always high. Write only while idle.
// Reset: asynchronous, active low; empties the pipeline and loads the register
// defaults (mask 38, threshold 76).
`timescale 1ns / 1ps
`default_nettype none

module tripod_gait_foot_position_top (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  wire  [2:0]       leg_number,
	input  wire  [4:0]       phase,
	input  wire  [8:0]       linear_speed,
	input  wire  [15:0]      heading,
	input  wire  [8:0]       turn_speed,
	output logic             out_valid,
	input  wire              out_ready,
	output logic signed [9:0] foot_x,
	output logic signed [9:0] foot_y,
	output logic signed [9:0] foot_z,
	input  wire              cfg_valid,
	output logic             cfg_ready,
	input  wire  [1:0]       cfg_index,
	input  wire  [8:0]       cfg_data
);
	import tgfp_pkg::*;

	localparam int unsigned NSTG  = 5 + ROT_STAGES;
	localparam int unsigned ROT0  = 3;

	// Configuration registers
	logic [5:0] mask_q;
	logic [8:0] thresh_q;

	// Pipeline control
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] adv;

	// Stage 1: tables and enables
	foot_pt_t   lpt_s1, tpt_s1;
	logic [23:0] lvg_s1;
	logic [8:0]  tv_s1;
	logic [15:0] hd_s1;
	logic        len_s1, ten_s1;

	// Stage 2: products
	logic signed [ACC_W-1:0] x0_s2, y0_s2;
	side_t       side_s2;
	logic [15:0] hd_s2;

	// Stage 3: quadrant turn
	cord_t cord_s3;
	side_t side_s3;

	// Stages 4 to 10: rotator
	cord_t cord_s4to10 [ROT_STAGES];
	side_t side_s4to10 [ROT_STAGES];

	// Stage 11: sums
	logic signed [SUM_W-1:0] sx_s11, sy_s11;
	logic [ZSUM_W-1:0]       zsum_s11;

	// Stage 12: results
	logic signed [9:0] fx_s12, fy_s12, fz_s12;

	// Front-end combinational signals
	logic [7:0] mask_ext;
	logic [5:0] ph_sum;
	logic [4:0] idx;

	// Back-end combinational signals
	logic signed [SUM_W-1:0] sx_sh, sy_sh;
	logic [ZSUM_W+3:0]       fz_full;
	cord_t cord_last;
	side_t side_last;

	// Take configuration writes at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= 6'd38;
			thresh_q <= 9'd76;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SHIFT_MASK:   mask_q   <= cfg_data[5:0];
				REG_SPEED_THRESH: thresh_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance a stage when it is empty or its successor advances
	always_comb begin
		adv[NSTG-1] = !vld_q[NSTG-1] || out_ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[NSTG-1];

	// Move valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Shift phase for the second tripod and wrap into the cycle
	assign mask_ext = {2'b00, mask_q};
	assign ph_sum   = {1'b0, phase} + (mask_ext[leg_number] ? 6'(HALF_STEPS) : 6'd0);
	assign idx      = (ph_sum >= 6'(STEPS_PER_CYCLE)) ?
	                  5'(ph_sum - 6'(STEPS_PER_CYCLE)) : ph_sum[4:0];

	// Stage 1: read tables, pre-scale linear speed by the rotator gain
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			lpt_s1 <= line_pt(idx);
			tpt_s1 <= turn_pt(idx);
			lvg_s1 <= 24'(linear_speed) * 24'(CORDIC_GAIN);
			tv_s1  <= turn_speed;
			hd_s1  <= heading;
			len_s1 <= linear_speed > thresh_q;
			ten_s1 <= turn_speed > thresh_q;
		end
	end

	// Stage 2: scale table offsets by speed
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			x0_s2        <= ACC_W'(lpt_s1.x) * ACC_W'($signed({1'b0, lvg_s1}));
			y0_s2        <= ACC_W'(lpt_s1.y) * ACC_W'($signed({1'b0, lvg_s1}));
			side_s2.tx   <= TURN_W'(tpt_s1.x) * TURN_W'($signed({1'b0, tv_s1}));
			side_s2.ty   <= TURN_W'(tpt_s1.y) * TURN_W'($signed({1'b0, tv_s1}));
			side_s2.zsum <= (len_s1 ? ZSUM_W'(lpt_s1.z) : '0)
			              + (ten_s1 ? ZSUM_W'(tpt_s1.z) : '0);
			side_s2.len  <= len_s1;
			side_s2.ten  <= ten_s1;
			hd_s2        <= hd_s1;
		end
	end

	// Stage 3: turn by whole quarters, load residual angle
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			case (hd_s2[15:14])
				2'd0: begin
					cord_s3.x <= x0_s2;
					cord_s3.y <= y0_s2;
				end
				2'd1: begin
					cord_s3.x <= -y0_s2;
					cord_s3.y <= x0_s2;
				end
				2'd2: begin
					cord_s3.x <= -x0_s2;
					cord_s3.y <= -y0_s2;
				end
				default: begin
					cord_s3.x <= y0_s2;
					cord_s3.y <= -x0_s2;
				end
			endcase
			cord_s3.z <= ANG_W'(hd_s2[13:0]);
			side_s3   <= side_s2;
		end
	end

	// Stages 4 to 10: rotator pairs, with side terms delayed alongside
	for (genvar g = 0; g < ROT_STAGES; g++) begin : g_rot
		cord_t cin;
		if (g == 0) begin : g_first
			assign cin = cord_s3;
			always_ff @(posedge clk) begin
				if (adv[ROT0]) begin
					side_s4to10[g] <= side_s3;
				end
			end
		end else begin : g_next
			assign cin = cord_s4to10[g-1];
			always_ff @(posedge clk) begin
				if (adv[ROT0+g]) begin
					side_s4to10[g] <= side_s4to10[g-1];
				end
			end
		end
		tgfp_cordic_pair #(
			.FIRST(g * ROT_PER_STAGE)
		) u_rot (
			.clk (clk),
			.en  (adv[ROT0+g]),
			.d   (cin),
			.q   (cord_s4to10[g])
		);
	end

	assign cord_last = cord_s4to10[ROT_STAGES-1];
	assign side_last = side_s4to10[ROT_STAGES-1];

	// Stage 11: add the linear and turning terms and the rounding half
	always_ff @(posedge clk) begin
		if (adv[NSTG-2]) begin
			sx_s11 <= (side_last.len ? SUM_W'(cord_last.x) : '0)
			        + (side_last.ten ? (SUM_W'(side_last.tx) <<< TURN_SHIFT) : '0)
			        + (SUM_W'(1) <<< ROUND_BIT);
			sy_s11 <= (side_last.len ? SUM_W'(cord_last.y) : '0)
			        + (side_last.ten ? (SUM_W'(side_last.ty) <<< TURN_SHIFT) : '0)
			        + (SUM_W'(1) <<< ROUND_BIT);
			zsum_s11 <= side_last.zsum;
		end
	end

	// Drop fraction bits and clamp
	assign sx_sh   = sx_s11 >>> FRAC_SHIFT;
	assign sy_sh   = sy_s11 >>> FRAC_SHIFT;
	assign fz_full = {zsum_s11, 4'b0000};

	// Stage 12: output register
	always_ff @(posedge clk) begin
		if (adv[NSTG-1]) begin
			if (sx_sh > XY_LIMIT) begin
				fx_s12 <= 10'(XY_LIMIT);
			end else if (sx_sh < -XY_LIMIT) begin
				fx_s12 <= 10'(-XY_LIMIT);
			end else begin
				fx_s12 <= sx_sh[9:0];
			end
			if (sy_sh > XY_LIMIT) begin
				fy_s12 <= 10'(XY_LIMIT);
			end else if (sy_sh < -XY_LIMIT) begin
				fy_s12 <= 10'(-XY_LIMIT);
			end else begin
				fy_s12 <= sy_sh[9:0];
			end
			if (fz_full > 10'(Z_LIMIT)) begin
				fz_s12 <= 10'(Z_LIMIT);
			end else begin
				fz_s12 <= fz_full;
			end
		end
	end

	assign foot_x = fx_s12;
	assign foot_y = fy_s12;
	assign foot_z = fz_s12;

	// A pipeline with any empty stage must take a word
	a_ready_on_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q != {NSTG{1'b1}}) |-> in_ready)
		else $error("in_ready low with an empty stage");

	// Occupancy grows by one on a lone input transfer
	a_fill_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !(out_valid && out_ready)) |=>
		($countones(vld_q) == $past($countones(vld_q)) + 1))
		else $error("pipeline occupancy did not grow");

	// Occupancy shrinks by one on a lone output transfer
	a_drain_count: assert property (@(posedge clk) disable iff (!arst_n)
		(!(in_valid && in_ready) && out_valid && out_ready) |=>
		($countones(vld_q) + 1 == $past($countones(vld_q))))
		else $error("pipeline occupancy did not shrink");

	// Planar results stay inside the clamp
	a_xy_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (foot_x <= 10'sd480 && foot_x >= -10'sd480 &&
		               foot_y <= 10'sd480 && foot_y >= -10'sd480))
		else $error("foot_x or foot_y out of range");

	// Lift is a whole unit count, never negative
	a_z_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!foot_z[9] && foot_z[3:0] == 4'd0))
		else $error("foot_z malformed");

endmodule

`default_nettype wire
